/* hdl/tile_event_histogram_scorer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the tile event histogram scorer.
// Each macro expects clk_i and rst_ni in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TILE_EVENT_HISTOGRAM_SCORER_MACROS_SVH
`define TILE_EVENT_HISTOGRAM_SCORER_MACROS_SVH

// Same-cycle implication.
`define TEHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tile histogram scorer check failed");

// Next-cycle implication.
`define TEHS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tile histogram scorer check failed");

`endif

/* hdl/tehs_pkg.sv */
// ----------------------------------------------------------------------------
// tehs_pkg
// Beat types, action codes and controller interface types for the tile
// event histogram scorer.
// ----------------------------------------------------------------------------
package tehs_pkg;

  typedef enum logic [1:0] {
    ACT_PICKUP  = 2'd0,
    ACT_DROPOFF = 2'd1,
    ACT_DRIVER  = 2'd2,
    ACT_QUERY   = 2'd3
  } action_e;

  localparam int unsigned TILE_BITS    = 12;
  localparam int unsigned OUT_BITS     = 16;
  localparam int unsigned SCORE_BITS   = 17;
  localparam int unsigned QUOT_BITS    = 17;
  localparam int unsigned DIV_CNT_BITS = 5;
  localparam logic [SCORE_BITS-1:0] Q_ONE = 17'h10000;

  typedef struct packed {
    action_e               action;
    logic [TILE_BITS-1:0]  tile;
    logic                  tile_valid;
  } in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0]   tile_pickups;
    logic [OUT_BITS-1:0]   tile_dropoffs;
    logic [OUT_BITS-1:0]   tile_drivers;
    logic [SCORE_BITS-1:0] hotspot;
    logic [SCORE_BITS-1:0] coldness;
  } out_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic row_write;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic known;
    logic max_zero;
    logic out_free;
  } status_t;

endpackage

/* hdl/tehs_ctrl.sv */
// ----------------------------------------------------------------------------
// tehs_ctrl
// Sequencer for the scorer: clearing pass, event update, query division
// and result hand-over.
// ----------------------------------------------------------------------------
module tehs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tehs_pkg::status_t status_i,
  output tehs_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ACT   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [tehs_pkg::DIV_CNT_BITS-1:0] CntLast =
    tehs_pkg::DIV_CNT_BITS'(tehs_pkg::QUOT_BITS - 1);

  logic [2:0] state_q, state_d;
  logic [tehs_pkg::DIV_CNT_BITS-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ACT;
        end
      end
      ST_ACT: begin
        if (status_i.is_query) begin
          if (status_i.known && !status_i.max_zero) begin
            cmd_o.div_load = 1'b1;
            cnt_d          = '0;
            state_d        = ST_DIV;
          end else begin
            state_d = ST_OUT;
          end
        end else begin
          cmd_o.row_write = status_i.known;
          state_d         = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* hdl/tehs_dp.sv */
// ----------------------------------------------------------------------------
// tehs_dp
// Counter memory, maximum register, restoring divider and output register
// of the scorer.
// ----------------------------------------------------------------------------
module tehs_dp #(
  parameter int unsigned TILE_COUNT = 4096,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tehs_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tehs_pkg::out_t    out_data_o,
  input  tehs_pkg::cmd_t    cmd_i,
  output tehs_pkg::status_t status_o
);

  localparam int unsigned AW = $clog2(TILE_COUNT);
  localparam int unsigned RW = 3 * COUNT_BITS;
  localparam logic [AW-1:0] AddrLast = AW'(TILE_COUNT - 1);

  typedef logic [COUNT_BITS-1:0] cnt_t;

  function automatic cnt_t bump(input cnt_t v);
    bump = (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [tehs_pkg::OUT_BITS-1:0] sat_out(input cnt_t v);
    sat_out = (32'(v) > 32'h0000_FFFF) ? 16'hFFFF : tehs_pkg::OUT_BITS'(v);
  endfunction

  logic [RW-1:0] mem [TILE_COUNT];
  logic [RW-1:0] row_q;
  logic [AW-1:0] clr_addr_q;
  logic [AW-1:0] addr_q;
  tehs_pkg::action_e action_q;
  logic known_q;
  cnt_t max_q;
  logic [COUNT_BITS:0] rem_q;
  logic [tehs_pkg::QUOT_BITS-1:0] quot_q;
  logic out_valid_q;
  tehs_pkg::out_t out_q;

  cnt_t row_p, row_d, row_r, new_p;
  logic [RW-1:0] wr_row;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic div_ge;
  logic [COUNT_BITS:0] div_diff;
  logic [tehs_pkg::SCORE_BITS-1:0] hot;

  assign row_p = row_q[RW-1 -: COUNT_BITS];
  assign row_d = row_q[2*COUNT_BITS-1 -: COUNT_BITS];
  assign row_r = row_q[COUNT_BITS-1:0];
  assign new_p = bump(row_p);

  always_comb begin
    wr_row = row_q;
    case (action_q)
      tehs_pkg::ACT_PICKUP:  wr_row[RW-1 -: COUNT_BITS]           = new_p;
      tehs_pkg::ACT_DROPOFF: wr_row[2*COUNT_BITS-1 -: COUNT_BITS] = bump(row_d);
      default:               wr_row[COUNT_BITS-1:0]               = bump(row_r);
    endcase
    if (cmd_i.clr_step) begin
      wr_row = '0;
    end
  end

  assign wr_en   = cmd_i.clr_step | cmd_i.row_write;
  assign wr_addr = cmd_i.clr_step ? clr_addr_q : addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (cmd_i.capture) begin
      row_q <= mem[AW'(in_data_i.tile)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q   <= AW'(in_data_i.tile);
      action_q <= in_data_i.action;
      known_q  <= in_data_i.tile_valid && (32'(in_data_i.tile) < 32'(TILE_COUNT));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      max_q      <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (cmd_i.row_write && (action_q == tehs_pkg::ACT_PICKUP) && (new_p > max_q)) begin
        max_q <= new_p;
      end
    end
  end

  // One quotient bit per step of the restoring division by the maximum.
  assign div_ge   = rem_q >= {1'b0, max_q};
  assign div_diff = div_ge ? (rem_q - {1'b0, max_q}) : rem_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q  <= {1'b0, row_p};
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= {div_diff[COUNT_BITS-1:0], 1'b0};
      quot_q <= {quot_q[tehs_pkg::QUOT_BITS-2:0], div_ge};
    end
  end

  always_comb begin
    hot = '0;
    if (known_q && (max_q != '0)) begin
      hot = (quot_q > tehs_pkg::Q_ONE) ? tehs_pkg::Q_ONE : quot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.tile_pickups  <= known_q ? sat_out(row_p) : '0;
      out_q.tile_dropoffs <= known_q ? sat_out(row_d) : '0;
      out_q.tile_drivers  <= known_q ? sat_out(row_r) : '0;
      out_q.hotspot       <= hot;
      out_q.coldness      <= tehs_pkg::Q_ONE - hot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.clr_last = clr_addr_q == AddrLast;
  assign status_o.is_query = action_q == tehs_pkg::ACT_QUERY;
  assign status_o.known    = known_q;
  assign status_o.max_zero = max_q == '0;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

/* hdl/tile_event_histogram_scorer.sv */
// ----------------------------------------------------------------------------
// tile_event_histogram_scorer: per-tile event counters with hotspot scores.
// Events read the counter row from memory, then write it back if the tile is known;
// queries run the 17-step restoring divider before the result beat, or skip it for an
// unknown tile or a zero maximum. After reset a clearing pass over all TILE_COUNT
// addresses zeroes the counters.
module tile_event_histogram_scorer #(
  parameter int unsigned TILE_COUNT = 4096,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tehs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tehs_pkg::out_t out_data_o
);

  tehs_pkg::cmd_t    cmd;
  tehs_pkg::status_t status;

  tehs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tehs_dp #(
    .TILE_COUNT (TILE_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

/* hdl/tehs_checker.sv */
// ----------------------------------------------------------------------------
// tehs_checker
// Port-level checks for the tile event histogram scorer, bound to the top.
// ----------------------------------------------------------------------------
`include "tile_event_histogram_scorer_macros.svh"

module tehs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input tehs_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input tehs_pkg::out_t out_data_o
);

  `TEHS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `TEHS_ASSERT_NXT(a_busy_after_beat, in_valid_i && in_ready_o, !in_ready_o)
  `TEHS_ASSERT_NXT(a_event_no_result, in_valid_i && in_ready_o && (in_data_i.action != tehs_pkg::ACT_QUERY), !$rose(out_valid_o))
  `TEHS_ASSERT_IMP(a_score_sum, out_valid_o, ({1'b0, out_data_o.hotspot} + {1'b0, out_data_o.coldness}) == 18'h10000)

endmodule

bind tile_event_histogram_scorer tehs_checker u_tehs_checker (.*);
